/* design/ple_pkg.sv */
// ----------------------------------------------------------------------------
// ple_pkg: shared types and codes for the positional list engine
// Command codes, status codes and the control group sent to every cell.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int POS_W  = 7;
    localparam int CNT_W  = 7;
    localparam int ST_W   = 2;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic ins;
        logic ers;
        logic wr;
        logic rd;
    } cell_ctl_t;

endpackage

/* design/ple_cell.sv */
// ----------------------------------------------------------------------------
// ple_cell: one storage cell of the list
// Holds one element; loads the new value, its lower neighbor on insert or
// its upper neighbor on erase, and drives its value on a read hit.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int IDX = 0,
    parameter int PW  = 7
) (
    input  logic                             clk,
    input  ple_pkg::cell_ctl_t               ctl,
    input  logic [PW-1:0]                    tgt,
    input  logic [ple_pkg::DATA_W-1:0]       wdata,
    input  logic [ple_pkg::DATA_W-1:0]       lower,
    input  logic [ple_pkg::DATA_W-1:0]       upper,
    output logic [ple_pkg::DATA_W-1:0]       data,
    output logic [ple_pkg::DATA_W-1:0]       tap
);

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [ple_pkg::DATA_W-1:0] data_reg;
    logic [ple_pkg::DATA_W-1:0] data_next;
    logic                       hit;
    logic                       above;

    assign hit   = (MY_IDX == tgt);
    assign above = (MY_IDX > tgt);

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (hit)
                data_next = wdata;
            else if (above)
                data_next = lower;
        end
        else if (ctl.ers)
        begin
            if (hit || above)
                data_next = upper;
        end
        else if (ctl.wr && hit)
        begin
            data_next = wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = (ctl.rd && hit) ? data_reg : '0;

endmodule

/* design/ple_ctrl.sv */
// ----------------------------------------------------------------------------
// ple_ctrl: command decode and element count
// Checks each command against the count, sets status and the cell controls,
// and updates the count on an accepted item.
// ----------------------------------------------------------------------------
module ple_ctrl #(
    parameter int CAPACITY = 64,
    parameter int PW       = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [ple_pkg::CMD_W-1:0]    command,
    input  logic [ple_pkg::POS_W-1:0]    position,
    output ple_pkg::cell_ctl_t           ctl,
    output logic [PW-1:0]                tgt,
    output logic [ple_pkg::CNT_W-1:0]    count_after,
    output logic [ple_pkg::ST_W-1:0]     status
);

    localparam logic [PW-1:0] CAP = PW'(CAPACITY);

    logic [PW-1:0]      count_reg;
    logic [PW-1:0]      count_next;
    logic [PW-1:0]      pos;
    ple_pkg::cell_ctl_t op;

    assign pos = PW'(position);

    always_comb
    begin
        op         = '0;
        count_next = count_reg;
        status     = ple_pkg::ST_OK;
        tgt        = pos;
        case (command)
            ple_pkg::CMD_APPEND:
            begin
                tgt = count_reg;
                if (count_reg >= CAP)
                    status = ple_pkg::ST_FULL;
                else
                begin
                    op.wr      = 1'b1;
                    count_next = count_reg + PW'(1);
                end
            end
            ple_pkg::CMD_POP:
            begin
                if (count_reg == '0)
                    status = ple_pkg::ST_EMPTY;
                else
                    count_next = count_reg - PW'(1);
            end
            ple_pkg::CMD_INSERT:
            begin
                if (pos > count_reg)
                    status = ple_pkg::ST_RANGE;
                else if (count_reg >= CAP)
                    status = ple_pkg::ST_FULL;
                else
                begin
                    op.ins     = 1'b1;
                    count_next = count_reg + PW'(1);
                end
            end
            ple_pkg::CMD_ERASE:
            begin
                if (count_reg == '0)
                    status = ple_pkg::ST_EMPTY;
                else if (pos >= count_reg)
                    status = ple_pkg::ST_RANGE;
                else
                begin
                    op.ers     = 1'b1;
                    count_next = count_reg - PW'(1);
                end
            end
            ple_pkg::CMD_READ:
            begin
                if (pos >= count_reg)
                    status = ple_pkg::ST_RANGE;
                else
                    op.rd = 1'b1;
            end
            ple_pkg::CMD_WRITE:
            begin
                if (pos >= count_reg)
                    status = ple_pkg::ST_RANGE;
                else
                    op.wr = 1'b1;
            end
            ple_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (accept)
            count_reg <= count_next;
    end

    assign ctl         = accept ? op : '0;
    assign count_after = count_next[ple_pkg::CNT_W-1:0];

endmodule

/* design/positional_list_engine.sv */
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list of signed 32-bit values
// A row of CAPACITY cells holds the list; insert and erase move every later
// element one cell, and each command returns one item.
//
//   channel  signals                                  direction
//   in       in_valid in_ready command position value  into block
//   out      out_valid out_ready read_value count status out of block
//
// One item per cycle while the output is taken: the whole row of cells updates in the accepting cycle.
// The result appears in the output register in the cycle after acceptance.
// Reset clears the count and the output valid; cell contents stay undefined.
// in_ready is low only while a held result is not being taken.
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ple_pkg::CMD_W-1:0]         command,
    input  logic [ple_pkg::POS_W-1:0]         position,
    input  logic signed [ple_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [ple_pkg::DATA_W-1:0] read_value,
    output logic [ple_pkg::CNT_W-1:0]         count,
    output logic [ple_pkg::ST_W-1:0]          status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

    logic                         accept;
    ple_pkg::cell_ctl_t           ctl;
    logic [PW-1:0]                tgt;
    logic [ple_pkg::CNT_W-1:0]    count_after;
    logic [ple_pkg::ST_W-1:0]     status_now;
    logic [ple_pkg::DATA_W-1:0]   cell_data [CAPACITY];
    logic [ple_pkg::DATA_W-1:0]   cell_tap  [CAPACITY];
    logic [ple_pkg::DATA_W-1:0]   rd_word;

    logic                         out_valid_reg;
    logic [ple_pkg::DATA_W-1:0]   read_value_reg;
    logic [ple_pkg::CNT_W-1:0]    count_reg;
    logic [ple_pkg::ST_W-1:0]     status_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    ple_ctrl #(
        .CAPACITY (CAPACITY),
        .PW       (PW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .command     (command),
        .position    (position),
        .ctl         (ctl),
        .tgt         (tgt),
        .count_after (count_after),
        .status      (status_now)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ple_pkg::DATA_W-1:0] lower;
        logic [ple_pkg::DATA_W-1:0] upper;

        if (i == 0)
        begin : g_first
            assign lower = '0;
        end
        else
        begin : g_mid_lo
            assign lower = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign upper = '0;
        end
        else
        begin : g_mid_hi
            assign upper = cell_data[i+1];
        end

        ple_cell #(
            .IDX (i),
            .PW  (PW)
        ) u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .tgt   (tgt),
            .wdata (value),
            .lower (lower),
            .upper (upper),
            .data  (cell_data[i]),
            .tap   (cell_tap[i])
        );
    end

    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_word = rd_word | cell_tap[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg <= rd_word;
            count_reg      <= count_after;
            status_reg     <= status_now;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign count      = count_reg;
    assign status     = status_reg;

endmodule
